// File: design/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;
  localparam logic [1:0] REQ_NUMBER = 2'd3;

  // Configuration register indexes.
  localparam logic REG_BUS_MODE    = 1'b0;
  localparam logic REG_PULSE_TICKS = 1'b1;

  localparam logic [19:0] PULSE_TICKS_RESET = 20'd100000;

  // DDRAM row base addresses and the ASCII code of the digit zero.
  localparam logic [7:0] ROW_BASE_0   = 8'h00;
  localparam logic [7:0] ROW_BASE_1   = 8'h40;
  localparam logic [7:0] ROW_BASE_2   = 8'h14;
  localparam logic [7:0] ROW_BASE_3   = 8'h54;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;

  // Reciprocal of ten for 16-bit operands: q = (n * RECIP_TEN) >> RECIP_SHIFT.
  localparam logic [16:0] RECIP_TEN   = 17'd52429;
  localparam int          RECIP_SHIFT = 19;
  localparam int          MAX_DIGITS  = 5;

  // One byte waiting to go out on the LCD bus.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } lcdws_byte_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = ROW_BASE_0;
      2'd1:    base = ROW_BASE_1;
      2'd2:    base = ROW_BASE_2;
      default: base = ROW_BASE_3;
    endcase
    return base;
  endfunction

endpackage

// File: design/lcdws_fifo.sv
// ----------------------------------------------------------------------------
// lcdws_fifo
// Short byte queue between the request front end and the bus sequencer.
// ----------------------------------------------------------------------------
module lcdws_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  lcdws_pkg::lcdws_byte_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output lcdws_pkg::lcdws_byte_t rd_data,
  output logic                 empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lcdws_pkg::lcdws_byte_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests and turns each into the bytes it sends, with RS and a
// marker on the final byte. Numbers are split into decimal digits first.
// ----------------------------------------------------------------------------
module lcdws_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             in_req_type,
  input  logic [7:0]             in_byte_value,
  input  logic [1:0]             in_row,
  input  logic [5:0]             in_column,
  input  logic [15:0]            in_number_value,
  output logic                   q_push,
  output lcdws_pkg::lcdws_byte_t q_data,
  input  logic                   q_full
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] num_r, num_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  dig_r [lcdws_pkg::MAX_DIGITS];
  logic        dig_we;

  logic [32:0] prod;
  logic [15:0] quo;
  logic [15:0] rem_full;
  logic [3:0]  rem;
  logic [7:0]  cur_sum;

  assign full = (state_r != FS_IDLE) || q_full;

  // Divide by ten through the reciprocal, remainder by shift-and-add.
  assign prod     = num_r * lcdws_pkg::RECIP_TEN;
  assign quo      = 16'(prod[32:lcdws_pkg::RECIP_SHIFT]);
  assign rem_full = num_r - ((quo << 3) + (quo << 1));
  assign rem      = rem_full[3:0];

  assign cur_sum = {2'b00, in_column} + lcdws_pkg::row_base(in_row);

  // Request sequencing.
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    dig_we    = 1'b0;
    q_push    = 1'b0;
    q_data    = '0;
    case (state_r)
      FS_IDLE: begin
        if (push && !full) begin
          if (in_req_type == lcdws_pkg::REQ_NUMBER) begin
            num_nxt   = in_number_value;
            cnt_nxt   = '0;
            state_nxt = FS_DIV;
          end else begin
            q_push      = 1'b1;
            q_data.rs   = (in_req_type == lcdws_pkg::REQ_DATA);
            q_data.data = (in_req_type == lcdws_pkg::REQ_CURSOR) ?
                          {1'b1, cur_sum[6:0]} : in_byte_value;
            q_data.last = 1'b1;
          end
        end
      end
      FS_DIV: begin
        dig_we  = 1'b1;
        num_nxt = quo;
        cnt_nxt = cnt_r + 3'd1;
        if (quo == '0) begin
          idx_nxt   = cnt_r;
          state_nxt = FS_EMIT;
        end
      end
      FS_EMIT: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_data.rs   = 1'b1;
          q_data.data = lcdws_pkg::ASCII_ZERO + {4'd0, dig_r[idx_r]};
          q_data.last = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = FS_IDLE;
          end else begin
            idx_nxt = idx_r - 3'd1;
          end
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working value and digit store carry no reset.
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    if (dig_we) begin
      dig_r[cnt_r] <= rem;
    end
  end

endmodule

// File: design/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Takes queued bytes and plays them out as held bus states: one or two
// transfers per byte, each an E-high state followed by an E-low state.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   bus_mode,
  input  logic [19:0]            pulse_ticks,
  output logic                   q_pop,
  input  lcdws_pkg::lcdws_byte_t q_data,
  input  logic                   q_empty,
  output logic                   empty,
  input  logic                   pop,
  output logic                   out_reg_select,
  output logic [7:0]             out_bus_data,
  output logic                   out_enable_line,
  output logic                   out_last_state
);

  lcdws_pkg::lcdws_byte_t cur_r;
  logic        cur_valid_r, cur_valid_nxt;
  logic        cur_mode_r;
  logic [1:0]  step_r, step_nxt;
  logic [19:0] timer_r, timer_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        produce;
  logic        final_step;
  logic [7:0]  state_data;

  assign empty = !out_valid_r;
  assign q_pop = !cur_valid_r && !q_empty;

  // A new bus state goes out once the hold time is over and the slot is free.
  assign produce    = cur_valid_r && (timer_r == '0) && (!out_valid_r || pop);
  assign final_step = cur_mode_r ? (step_r == 2'd3) : (step_r == 2'd1);

  always_comb begin
    if (cur_mode_r) begin
      state_data = step_r[1] ? {cur_r.data[3:0], 4'd0} : {cur_r.data[7:4], 4'd0};
    end else begin
      state_data = cur_r.data;
    end
  end

  // Control update.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    timer_nxt     = (timer_r != '0) ? timer_r - 20'd1 : '0;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (produce) begin
      out_valid_nxt = 1'b1;
      timer_nxt     = pulse_ticks - 20'd1;
      step_nxt      = step_r + 2'd1;
      if (final_step) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Current byte and output beat payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r      <= q_data;
      cur_mode_r <= bus_mode;
    end
    if (produce) begin
      out_reg_select  <= cur_r.rs;
      out_bus_data    <= state_data;
      out_enable_line <= !step_r[0];
      out_last_state  <= cur_r.last && final_step;
    end
  end

endmodule

// File: design/char_lcd_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_unit
// Character LCD write sequencer: requests in, held bus states out.
// ----------------------------------------------------------------------------
// Requests enter through push/full: a command byte, a data byte, a cursor
// position or a 16-bit number printed in decimal. Each bus state (RS, data
// lines, E level, last marker) leaves as one beat through empty/pop.
// A byte is two bus states on an eight-bit bus and four in nibble mode.
// Successive bus states are spaced apart by the hold timer in the back
// end, which is loaded from pulse_ticks; this timer sets the throughput.
// The first beat of a byte request passes through the byte queue and the
// back end's current-byte register before it reaches the result ports. A
// number first has its decimal digits split off one by one in the divider,
// then its digits are queued most significant first, and full stays high
// until all of its digits are queued.
// Byte requests are accepted back to back while the byte queue has room.
// If the receiver stalls, the current beat waits and the back end holds
// the next one; the queue then fills and full rises.
// Reset empties the queue and all stages; bus_mode resets to eight-bit and
// pulse_ticks to 100000. Registers are at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_byte_value,
  input  logic [1:0]  in_row,
  input  logic [5:0]  in_column,
  input  logic [15:0] in_number_value,
  // Bus state channel.
  output logic        empty,
  input  logic        pop,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_data,
  output logic        out_enable_line,
  output logic        out_last_state,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        bus_mode_r;
  logic [19:0] pulse_ticks_r;
  logic        cfg_wr;

  lcdws_pkg::lcdws_byte_t fq_wdata, fq_rdata;
  logic fq_push, fq_full, fq_pop, fq_empty;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r    <= 1'b0;
      pulse_ticks_r <= lcdws_pkg::PULSE_TICKS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        lcdws_pkg::REG_BUS_MODE:    bus_mode_r    <= pwdata[0];
        lcdws_pkg::REG_PULSE_TICKS: pulse_ticks_r <= pwdata[19:0];
        default:                    bus_mode_r    <= bus_mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lcdws_pkg::REG_BUS_MODE:    prdata = {31'd0, bus_mode_r};
      lcdws_pkg::REG_PULSE_TICKS: prdata = {12'd0, pulse_ticks_r};
      default:                    prdata = '0;
    endcase
  end

  lcdws_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_number_value (in_number_value),
    .q_push          (fq_push),
    .q_data          (fq_wdata),
    .q_full          (fq_full)
  );

  lcdws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .empty   (fq_empty)
  );

  lcdws_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bus_mode        (bus_mode_r),
    .pulse_ticks     (pulse_ticks_r),
    .q_pop           (fq_pop),
    .q_data          (fq_rdata),
    .q_empty         (fq_empty),
    .empty           (empty),
    .pop             (pop),
    .out_reg_select  (out_reg_select),
    .out_bus_data    (out_bus_data),
    .out_enable_line (out_enable_line),
    .out_last_state  (out_last_state)
  );

endmodule

// File: tb/char_lcd_write_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_unit_test
// Self-checking bench for the character LCD write sequencer.
// ----------------------------------------------------------------------------
// Requests go in through push/full and every held bus state comes back as one
// beat through empty/pop. A short table of directed requests comes first.
// Rows whose bus byte is obvious carry it typed in. All other rows, and the
// random requests after them, are checked against a predictor that expands
// each request into its E-high/E-low bus states. The run covers both bus
// modes and several hold times. It writes the largest hold time and reads it
// back, but sends no request at that setting. Both sides idle at random,
// except in one phase with no idling at all.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One request as it appears on the input ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  column;
    logic [15:0] number_value;
  } lcd_request_t;

  // One held bus state as it appears on the result ports.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       e;
    logic       last;
  } lcd_bus_state_t;

  // Directed row: bus mode, request, and optionally the single byte it sends.
  typedef struct packed {
    logic        bus_mode;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  column;
    logic [15:0] number_value;
    logic        gold;
    logic        gold_rs;
    logic [7:0]  gold_byte;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:22] = '{
    // Eight-bit bus, bus mode from reset.
    '{1'b0, lcdws_pkg::REQ_CMD,    8'h00, 2'd0, 6'd0,  16'd0,     1'b1, 1'b0, 8'h00},
    '{1'b0, lcdws_pkg::REQ_CMD,    8'hFF, 2'd3, 6'd63, 16'hFFFF,  1'b1, 1'b0, 8'hFF},
    '{1'b0, lcdws_pkg::REQ_DATA,   8'h00, 2'd0, 6'd0,  16'd0,     1'b1, 1'b1, 8'h00},
    '{1'b0, lcdws_pkg::REQ_DATA,   8'hFF, 2'd0, 6'd0,  16'd0,     1'b1, 1'b1, 8'hFF},
    '{1'b0, lcdws_pkg::REQ_DATA,   8'hA5, 2'd2, 6'd21, 16'd1234,  1'b1, 1'b1, 8'hA5},
    '{1'b0, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd0, 6'd0,  16'd0,     1'b1, 1'b0, 8'h80},
    '{1'b0, lcdws_pkg::REQ_CURSOR, 8'hFF, 2'd1, 6'd39, 16'd0,     1'b1, 1'b0, 8'hE7},
    '{1'b0, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd2, 6'd0,  16'd0,     1'b1, 1'b0, 8'h94},
    '{1'b0, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd3, 6'd39, 16'd0,     1'b1, 1'b0, 8'hFB},
    // A column past the line end wraps inside the seven-bit address.
    '{1'b0, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd3, 6'd63, 16'd0,     1'b1, 1'b0, 8'h93},
    // Zero prints a single '0' digit.
    '{1'b0, lcdws_pkg::REQ_NUMBER, 8'hFF, 2'd3, 6'd63, 16'd0,     1'b1, 1'b1, 8'h30},
    '{1'b0, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd9,     1'b1, 1'b1, 8'h39},
    '{1'b0, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd10,    1'b0, 1'b0, 8'h00},
    '{1'b0, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd65535, 1'b0, 1'b0, 8'h00},
    // Four-bit bus.
    '{1'b1, lcdws_pkg::REQ_CMD,    8'hFF, 2'd0, 6'd0,  16'd0,     1'b1, 1'b0, 8'hFF},
    '{1'b1, lcdws_pkg::REQ_CMD,    8'h00, 2'd0, 6'd0,  16'd0,     1'b1, 1'b0, 8'h00},
    '{1'b1, lcdws_pkg::REQ_DATA,   8'h5A, 2'd0, 6'd0,  16'd0,     1'b1, 1'b1, 8'h5A},
    '{1'b1, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd1, 6'd63, 16'd0,     1'b1, 1'b0, 8'hFF},
    '{1'b1, lcdws_pkg::REQ_CURSOR, 8'h00, 2'd2, 6'd21, 16'd0,     1'b0, 1'b0, 8'h00},
    '{1'b1, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd0,     1'b1, 1'b1, 8'h30},
    // Five digits in nibble mode give the longest burst of beats.
    '{1'b1, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd65535, 1'b0, 1'b0, 8'h00},
    '{1'b1, lcdws_pkg::REQ_NUMBER, 8'h00, 2'd0, 6'd0,  16'd10000, 1'b0, 1'b0, 8'h00},
    '{1'b1, lcdws_pkg::REQ_NUMBER, 8'hC3, 2'd2, 6'd45, 16'd12345, 1'b0, 1'b0, 8'h00}
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_req_type;
  logic [7:0]  in_byte_value;
  logic [1:0]  in_row;
  logic [5:0]  in_column;
  logic [15:0] in_number_value;
  logic        empty;
  logic        pop;
  logic        out_reg_select;
  logic [7:0]  out_bus_data;
  logic        out_enable_line;
  logic        out_last_state;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the configuration registers, as last written.
  logic        mode_now;
  logic [19:0] ticks_now;

  // When set, neither side idles.
  bit          calm;

  lcd_bus_state_t pending_states[$];
  int             mismatch_count;
  int             beats_checked;
  int             requests_sent;

  char_lcd_write_sequencer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_number_value (in_number_value),
    .empty           (empty),
    .pop             (pop),
    .out_reg_select  (out_reg_select),
    .out_bus_data    (out_bus_data),
    .out_enable_line (out_enable_line),
    .out_last_state  (out_last_state),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = ~clk;
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

  // One transfer is two held states: E high, then E low.
  function automatic void queue_transfer(input logic rs, input logic [7:0] data,
                                         input logic last_byte);
    lcd_bus_state_t st;
    st.rs   = rs;
    st.data = data;
    st.e    = 1'b1;
    st.last = 1'b0;
    pending_states.push_back(st);
    st.e    = 1'b0;
    st.last = last_byte;
    pending_states.push_back(st);
  endfunction

  // A byte is one transfer on the eight-bit bus, two nibbles on the four-bit bus.
  function automatic void queue_byte(input logic rs, input logic [7:0] value,
                                     input logic last_byte);
    if (mode_now) begin
      queue_transfer(rs, {value[7:4], 4'h0}, 1'b0);
      queue_transfer(rs, {value[3:0], 4'h0}, last_byte);
    end else begin
      queue_transfer(rs, value, last_byte);
    end
  endfunction

  // Expands one request into the bus states it should produce.
  function automatic void predict_bus_states(input lcd_request_t req);
    logic [7:0]  base;
    logic [7:0]  addr;
    logic [15:0] rest;
    logic [3:0]  digits [0:4];
    int          count;
    case (req.kind)
      lcdws_pkg::REQ_CMD: begin
        queue_byte(1'b0, req.byte_value, 1'b1);
      end
      lcdws_pkg::REQ_DATA: begin
        queue_byte(1'b1, req.byte_value, 1'b1);
      end
      lcdws_pkg::REQ_CURSOR: begin
        case (req.row)
          2'd0:    base = lcdws_pkg::ROW_BASE_0;
          2'd1:    base = lcdws_pkg::ROW_BASE_1;
          2'd2:    base = lcdws_pkg::ROW_BASE_2;
          default: base = lcdws_pkg::ROW_BASE_3;
        endcase
        addr = (({2'b00, req.column} + base) & 8'h7F) | 8'h80;
        queue_byte(1'b0, addr, 1'b1);
      end
      default: begin
        // Peel decimal digits least significant first, send most significant first.
        rest  = req.number_value;
        count = 0;
        do begin
          digits[count] = 4'(rest % 16'd10);
          rest          = rest / 16'd10;
          count++;
        end while (rest != 16'd0);
        for (int i = count - 1; i >= 0; i--) begin
          queue_byte(1'b1, lcdws_pkg::ASCII_ZERO + {4'h0, digits[i]}, i == 0);
        end
      end
    endcase
  endfunction

  // Reads a register and compares the implemented bits.
  task automatic check_register(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = (idx == lcdws_pkg::REG_BUS_MODE) ? {31'd0, prdata[0]} : {12'd0, prdata[19:0]};
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, got);
      mismatch_count++;
    end
  endtask

  // Writes a register, updates the shadow and reads it back right after.
  task automatic set_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lcdws_pkg::REG_BUS_MODE) begin
      mode_now = value[0];
    end else begin
      ticks_now = value[19:0];
    end
    @(negedge clk);
    check_register(idx, value);
  endtask

  // Offers one request and records its bus states once it is accepted.
  // Entered and left at a falling edge; push stays high for a following request.
  task automatic send_request(input lcd_request_t req, input logic gold,
                              input logic gold_rs, input logic [7:0] gold_byte);
    while (!calm && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    in_req_type     <= req.kind;
    in_byte_value   <= req.byte_value;
    in_row          <= req.row;
    in_column       <= req.column;
    in_number_value <= req.number_value;
    do @(posedge clk); while (full);
    if (gold) begin
      queue_byte(gold_rs, gold_byte, 1'b1);
    end else begin
      predict_bus_states(req);
    end
    requests_sent++;
    @(negedge clk);
  endtask

  // Drops push and waits until every expected beat has been taken.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (pending_states.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // One configuration setting followed by random requests.
  task automatic run_random_phase(input logic mode, input logic [19:0] ticks,
                                  input int count, input bit no_idle);
    lcd_request_t req;
    wait_for_drain();
    set_register(lcdws_pkg::REG_BUS_MODE, {31'd0, mode});
    set_register(lcdws_pkg::REG_PULSE_TICKS, {12'd0, ticks});
    calm = no_idle;
    for (int n = 0; n < count; n++) begin
      req.kind       = 2'($urandom_range(0, 3));
      req.byte_value = 8'($urandom_range(0, 255));
      req.row        = 2'($urandom_range(0, 3));
      // Mostly real columns, sometimes past the line end.
      req.column     = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                                   : 6'($urandom_range(0, 39));
      // Short numbers as often as long ones.
      case ($urandom_range(0, 3))
        0:       req.number_value = 16'($urandom_range(0, 9));
        1:       req.number_value = 16'($urandom_range(10, 999));
        default: req.number_value = 16'($urandom_range(0, 65535));
      endcase
      send_request(req, 1'b0, 1'b0, 8'h00);
    end
  endtask

  // Receiver: pops at random and checks each beat against the oldest expectation.
  initial begin
    lcd_bus_state_t want;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      pop <= calm || ($urandom_range(0, 99) >= 15);
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_states.size() == 0) begin
          $error("unexpected beat: reg_select=%0b bus_data=%h enable_line=%0b last_state=%0b",
                 out_reg_select, out_bus_data, out_enable_line, out_last_state);
          mismatch_count++;
        end else begin
          want = pending_states.pop_front();
          beats_checked++;
          if (out_reg_select !== want.rs) begin
            $error("reg_select: expected %0b, got %0b", want.rs, out_reg_select);
            mismatch_count++;
          end
          if (out_bus_data !== want.data) begin
            $error("bus_data: expected %h, got %h", want.data, out_bus_data);
            mismatch_count++;
          end
          if (out_enable_line !== want.e) begin
            $error("enable_line: expected %0b, got %0b", want.e, out_enable_line);
            mismatch_count++;
          end
          if (out_last_state !== want.last) begin
            $error("last_state: expected %0b, got %0b", want.last, out_last_state);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    lcd_request_t req;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_req_type     = lcdws_pkg::REQ_CMD;
    in_byte_value   = 8'h00;
    in_row          = 2'd0;
    in_column       = 6'd0;
    in_number_value = 16'd0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 3'd0;
    pwdata          = 32'd0;
    mode_now        = 1'b0;
    ticks_now       = lcdws_pkg::PULSE_TICKS_RESET;
    calm            = 1'b0;
    mismatch_count  = 0;
    beats_checked   = 0;
    requests_sent   = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values, then a short hold time so the run stays quick.
    check_register(lcdws_pkg::REG_BUS_MODE, 32'd0);
    check_register(lcdws_pkg::REG_PULSE_TICKS, {12'd0, lcdws_pkg::PULSE_TICKS_RESET});
    set_register(lcdws_pkg::REG_PULSE_TICKS, 32'd1);

    // Directed table; the bus mode switches once the earlier rows have drained.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (DIRECTED_ROWS[i].bus_mode != mode_now) begin
        wait_for_drain();
        set_register(lcdws_pkg::REG_BUS_MODE, {31'd0, DIRECTED_ROWS[i].bus_mode});
      end
      req.kind         = DIRECTED_ROWS[i].kind;
      req.byte_value   = DIRECTED_ROWS[i].byte_value;
      req.row          = DIRECTED_ROWS[i].row;
      req.column       = DIRECTED_ROWS[i].column;
      req.number_value = DIRECTED_ROWS[i].number_value;
      send_request(req, DIRECTED_ROWS[i].gold, DIRECTED_ROWS[i].gold_rs,
                   DIRECTED_ROWS[i].gold_byte);
    end

    run_random_phase(1'b0, 20'd1, 20, 1'b0);
    run_random_phase(1'b1, 20'd1, 20, 1'b1);

    // Largest hold time: written and read back only, it would take too long to run.
    wait_for_drain();
    set_register(lcdws_pkg::REG_PULSE_TICKS, 32'hF_FFFF);

    run_random_phase(1'b0, 20'd3, 20, 1'b0);
    run_random_phase(1'b1, 20'd6, 20, 1'b0);

    // Let any stray beat show up before the verdict.
    wait_for_drain();
    repeat (4 * int'(ticks_now) + 40) @(posedge clk);

    $display("Sent %0d requests and checked %0d bus-state beats,", requests_sent,
             beats_checked);
    $display("over eight-bit and nibble bus modes and hold times of 1 to 6 cycles.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: char_lcd_write_sequencer_unit.f
design/lcdws_pkg.sv
design/lcdws_fifo.sv
design/lcdws_front.sv
design/lcdws_back.sv
design/char_lcd_write_sequencer_unit.sv
tb/char_lcd_write_sequencer_unit_test.sv
